>>> hdl/adc_channel_scan_sequencer_defines.svh
// ----------------------------------------------------------------------------
// ADC channel scan sequencer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge of clock.
// ----------------------------------------------------------------------------
`ifndef ADC_CHANNEL_SCAN_SEQUENCER_DEFINES_SVH
`define ADC_CHANNEL_SCAN_SEQUENCER_DEFINES_SVH

// Property checked outside reset
`define ADCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every edge, reset included
`define ADCS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/adcs_pkg.sv
// ----------------------------------------------------------------------------
// ADC channel scan sequencer package
// Sizes, codes, word types and controller states shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adcs_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 10;
   localparam int MASK_BITS    = 8;
   localparam int CHAN_BITS    = $clog2(NUM_CHANNELS);
   localparam int PTR_BITS     = $clog2(NUM_CHANNELS + 1);
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam int REF_BITS     = 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_CHANNEL_MASK     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_REFERENCE_SELECT = 2'd1;

   // Action codes of a request word
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_DONE  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  sample;
      logic [2:0]  channel;
   } req_word_type;

   typedef struct packed {
      logic        start_conversion;
      logic [2:0]  mux_channel;
      logic [1:0]  reference_out;
      logic [9:0]  read_value;
   } rsp_word_type;

   // Access to the result store
   typedef struct packed {
      logic                   wr_en;
      logic [CHAN_BITS-1:0]   wr_addr;
      logic [SAMPLE_BITS-1:0] wr_data;
      logic                   rd_en;
      logic [CHAN_BITS-1:0]   rd_addr;
   } store_req_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } ctrl_state_type;

endpackage

>>> hdl/adcs_result_store.sv
// ----------------------------------------------------------------------------
// ADC scan result store
// Per-channel sample memory with a registered read port. Entry valid bits
// cleared by reset make unwritten slots read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adcs_result_store (
   input  logic                            clock,
   input  logic                            reset,
   input  adcs_pkg::store_req_type         store_req,
   output logic [adcs_pkg::SAMPLE_BITS-1:0] rd_data
);
   import adcs_pkg::*;

   logic [SAMPLE_BITS-1:0]  mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic [SAMPLE_BITS-1:0]  rd_data_ff;
   logic                    rd_valid_ff;

   // Write sample into its slot
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   // Mark written slots
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (store_req.wr_en) begin
         valid_ff[store_req.wr_addr] <= 1'b1;
      end
   end

   // Register read data and hold it until the next read
   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (store_req.rd_en) begin
         rd_valid_ff <= valid_ff[store_req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hdl/adc_channel_scan_sequencer.sv
// A response word is valid in the cycle after its request word is taken.
// One request at a time: req_ready stays low while a response word waits, so a
// new request is taken only after that response word is accepted.
// Reset clears the scan pointer, mask, reference select and the result slot
// valid bits at once; every slot then reads as zero. No clearing pass.
// ----------------------------------------------------------------------------
// ADC channel scan sequencer
// Round-robin channel scan over a mask, with a per-channel result store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_channel_scan_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  adcs_pkg::req_word_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output adcs_pkg::rsp_word_type             rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [adcs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [adcs_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import adcs_pkg::*;

   ctrl_state_type         state_ff, state_in;
   logic [PTR_BITS-1:0]    ptr_ff, ptr_in;
   logic [MASK_BITS-1:0]   mask_ff;
   logic [REF_BITS-1:0]    ref_ff;
   logic                   start_ff, start_in;
   logic [2:0]             mux_ff, mux_in;
   logic [1:0]             refo_ff, refo_in;
   logic                   rd_sel_ff, rd_sel_in;

   logic                   req_fire;
   logic                   csr_fire;
   logic                   is_start, is_done, is_read;
   logic                   found;
   logic [CHAN_BITS-1:0]   pick;
   logic                   launch;
   logic [PTR_BITS-1:0]    slot_ptr;
   store_req_type          store_req;
   logic [SAMPLE_BITS-1:0] rd_data;

   assign req_fire = req_valid && req_ready;
   assign csr_fire = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   // Decode the request word
   always_comb begin
      is_start = (req_data.action == ACT_START);
      is_done  = (req_data.action == ACT_DONE) && (ptr_ff != '0);
      is_read  = (req_data.action == ACT_READ) && (int'(req_data.channel) < NUM_CHANNELS);
   end

   // Search upward from the pointer for the next enabled channel, wrapping
   always_comb begin
      logic [PTR_BITS:0] pos;
      found = 1'b0;
      pick  = '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         pos = {1'b0, ptr_ff} + (PTR_BITS + 1)'(k);
         if (pos >= (PTR_BITS + 1)'(NUM_CHANNELS)) begin
            pos = pos - (PTR_BITS + 1)'(NUM_CHANNELS);
         end
         if (!found && mask_ff[pos[CHAN_BITS-1:0]]) begin
            found = 1'b1;
            pick  = pos[CHAN_BITS-1:0];
         end
      end
   end

   assign launch   = (is_start || is_done) && found;
   assign slot_ptr = ptr_ff - PTR_BITS'(1);

   // Store the sample of a done word, read the slot of every word
   always_comb begin
      store_req.wr_en   = req_fire && is_done;
      store_req.wr_addr = slot_ptr[CHAN_BITS-1:0];
      store_req.wr_data = req_data.sample;
      store_req.rd_en   = req_fire;
      store_req.rd_addr = req_data.channel[CHAN_BITS-1:0];
   end

   adcs_result_store u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         ref_ff  <= '0;
      end else if (csr_fire) begin
         if (csr_index == REG_CHANNEL_MASK) begin
            mask_ff <= csr_wdata[MASK_BITS-1:0];
         end
         if (csr_index == REG_REFERENCE_SELECT) begin
            ref_ff <= csr_wdata[REF_BITS-1:0];
         end
      end
   end

   // Advance the scan pointer past a launched channel; a mask write clears it
   always_comb begin
      ptr_in = ptr_ff;
      if (csr_fire && csr_index == REG_CHANNEL_MASK) begin
         ptr_in = '0;
      end else if (req_fire && launch) begin
         ptr_in = PTR_BITS'(pick) + PTR_BITS'(1);
      end
   end

   // Capture the launch fields of the word being taken
   always_comb begin
      start_in  = start_ff;
      mux_in    = mux_ff;
      refo_in   = refo_ff;
      rd_sel_in = rd_sel_ff;
      if (req_fire) begin
         start_in  = launch;
         mux_in    = launch ? 3'(pick) : 3'd0;
         refo_in   = launch ? ref_ff : 2'd0;
         rd_sel_in = is_read;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SEND: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      mux_ff    <= mux_in;
      refo_ff   <= refo_in;
      rd_sel_ff <= rd_sel_in;
   end

   // Assemble the response word
   always_comb begin
      rsp_data.start_conversion = start_ff;
      rsp_data.mux_channel      = mux_ff;
      rsp_data.reference_out    = refo_ff;
      rsp_data.read_value       = rd_sel_ff ? rd_data : '0;
   end

endmodule

>>> hdl/adcs_checker.sv
// ----------------------------------------------------------------------------
// ADC channel scan sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adc_channel_scan_sequencer_defines.svh"

module adcs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input adcs_pkg::rsp_word_type rsp_data
);
   import adcs_pkg::*;

   // A stalled response holds
   `ADCS_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response word changed while stalled")

   // Every taken request yields a response word on the next cycle
   `ADCS_ASSERT(a_req_to_rsp, req_valid && req_ready |=> rsp_valid, "no response after request")

   // Launch fields are zero when nothing is launched
   `ADCS_ASSERT(a_idle_fields, rsp_valid && !rsp_data.start_conversion |-> rsp_data.mux_channel == 3'd0 && rsp_data.reference_out == 2'd0, "launch fields set without launch")

   // A launch never carries read data
   `ADCS_ASSERT(a_launch_no_read, rsp_valid && rsp_data.start_conversion |-> rsp_data.read_value == '0, "read data on a launch word")

   // No response word right after reset
   `ADCS_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind adc_channel_scan_sequencer adcs_checker u_adcs_checker (.*);
